/* rtl/rwhp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_pkg
// Shared constants, types and helpers of the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package rwhp_pkg;

  localparam int LEN_W     = 32;
  localparam int DIV_W     = 22;
  localparam int CNT_W     = 6;
  localparam int DSTEP_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_MAGIC = 2'd2;

  localparam logic [3:0] STS_OK_STD      = 4'd0;
  localparam logic [3:0] STS_OK_OTHER    = 4'd1;
  localparam logic [3:0] STS_TOO_SMALL   = 4'd2;
  localparam logic [3:0] STS_NOT_RIFF    = 4'd3;
  localparam logic [3:0] STS_NOT_WAVE    = 4'd4;
  localparam logic [3:0] STS_FMT_SMALL   = 4'd5;
  localparam logic [3:0] STS_NOT_PCM     = 4'd6;
  localparam logic [3:0] STS_NO_CHANNELS = 4'd7;
  localparam logic [3:0] STS_BAD_RATE    = 4'd8;
  localparam logic [3:0] STS_NO_BITS     = 4'd9;
  localparam logic [3:0] STS_DATA_EARLY  = 4'd10;
  localparam logic [3:0] STS_BAD_TAG     = 4'd11;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] MIN_FILE_LENGTH = 32'd28;
  localparam logic [15:0] FMT_PCM         = 16'h0001;
  localparam logic [15:0] FMT_EXTENSIBLE  = 16'hFFFE;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_DONE,
    PH_DIV
  } phase_t;

  typedef struct packed {
    logic             clear;
    logic             proc;
    logic             head;
    logic             chdr;
    logic             fmt;
    logic             skip;
    logic             fmt_enter;
    logic             skip_chunk;
    logic             fmt_rest;
    logic             fcap_set;
    logic             div_start;
    logic             div_step;
    logic             emit;
    logic             emit_fmt;
    logic             emit_div;
    logic [3:0]       emit_status;
    logic [CNT_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic len_small;
    logic pos_is3;
    logic pos_is11;
    logic pos_lt3;
    logic magic_ok;
    logic wave_ok;
    logic tag_fmt;
    logic tag_data;
    logic tag_print;
    logic size_lt16;
    logic size_zero;
    logic len_lt18;
    logic ext_ok;
    logic fmt_bad;
    logic chan_zero;
    logic rate_bad;
    logic bits_zero;
    logic rest_zero;
    logic fcap_cur;
    logic std_ok;
    logic skip_last;
    logic div_last;
    logic out_busy;
  } flags_t;

  function automatic logic printable(input logic [31:0] tag);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (tag[8*i +: 8] < 8'd32 || tag[8*i +: 8] > 8'd126) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [13:0] bpc_of(input logic [15:0] bits);
    logic [16:0] sum;
    sum = {1'b0, bits} + 17'd7;
    return sum[16:3];
  endfunction

endpackage

/* rtl/riff_wave_header_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// Byte-serial WAV header parser: one result per file on error, data or end.
// Results: a result is registered, valid in the cycle after the byte that causes
//   it; at the data chunk it is registered when the frame divider finishes.
// Input: one byte per cycle unless a held result is stalled; the data chunk
//   holds input off while the radix-2 frame divider runs, one quotient bit per cycle.
// Reset: synchronous rst idles the parser and clears the config registers.
// ----------------------------------------------------------------------------
module riff_wave_header_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           first_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     status,
  output logic [13:0]                    bytes_per_channel,
  output logic [7:0]                     channels,
  output logic [15:0]                    sample_rate,
  output logic [31:0]                    data_offset,
  output logic [31:0]                    sample_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rwhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import rwhp_pkg::*;

  cmd_t   cmd;
  flags_t flg;

  assign cfg_ready = 1'b1;

  rwhp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .flg        (flg),
    .cmd        (cmd)
  );

  rwhp_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .data_byte         (data_byte),
    .cmd               (cmd),
    .flg               (flg),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .status            (status),
    .bytes_per_channel (bytes_per_channel),
    .channels          (channels),
    .sample_rate       (sample_rate),
    .data_offset       (data_offset),
    .sample_count      (sample_count)
  );

endmodule

/* rtl/rwhp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_ctrl
// Parse sequencer: phase, header byte counter and per-byte commands.
// ----------------------------------------------------------------------------
module rwhp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             first_byte,
  input  logic             last_byte,
  input  rwhp_pkg::flags_t flg,
  output rwhp_pkg::cmd_t   cmd
);
  import rwhp_pkg::*;

  phase_t           state;
  phase_t           state_next;
  phase_t           ph_eff;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_cur;
  logic             fire;
  logic             fcap_fin;

  assign in_stall  = (state == PH_DIV) || flg.out_busy;
  assign fire      = in_valid && !in_stall;
  assign ph_eff    = first_byte ? PH_HEAD : state;
  assign count_cur = first_byte ? '0 : count;

  always_comb begin
    cmd      = '0;
    cmd.k    = count_cur;
    fcap_fin = 1'b0;
    if (state == PH_DIV) begin
      cmd.div_step = 1'b1;
      cmd.emit_div = flg.div_last;
    end else if (fire) begin
      cmd.clear = first_byte;
      if (first_byte && flg.len_small) begin
        cmd.emit        = 1'b1;
        cmd.emit_status = STS_TOO_SMALL;
      end else begin
        case (ph_eff)
          PH_HEAD: begin
            cmd.proc = 1'b1;
            cmd.head = 1'b1;
            if (flg.pos_is3 && !flg.magic_ok) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STS_NOT_RIFF;
            end else if (flg.pos_is11 && !flg.wave_ok) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STS_NOT_WAVE;
            end else if (!flg.pos_is11 && last_byte) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = flg.pos_lt3 ? STS_NOT_RIFF : STS_NOT_WAVE;
            end
          end
          PH_CHDR: begin
            cmd.proc = 1'b1;
            cmd.chdr = 1'b1;
            if (count_cur == 6'd7) begin
              if (flg.tag_fmt) begin
                if (flg.size_lt16) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = STS_FMT_SMALL;
                end else begin
                  cmd.fmt_enter = 1'b1;
                end
              end else if (flg.tag_data) begin
                if (!flg.fcap_cur) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = STS_DATA_EARLY;
                end else begin
                  cmd.div_start   = 1'b1;
                  cmd.emit_status = flg.std_ok ? STS_OK_STD : STS_OK_OTHER;
                end
              end else if (!flg.tag_print) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STS_BAD_TAG;
              end else begin
                cmd.skip_chunk = 1'b1;
              end
            end
          end
          PH_FMT: begin
            cmd.proc = 1'b1;
            cmd.fmt  = 1'b1;
            if ((count_cur == 6'd15 && flg.len_lt18) ||
                (count_cur == 6'd17 && !flg.ext_ok) || count_cur == 6'd39) begin
              cmd.fmt_rest = 1'b1;
              if (flg.fmt_bad) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STS_NOT_PCM;
              end else if (flg.chan_zero) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STS_NO_CHANNELS;
              end else if (flg.rate_bad) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STS_BAD_RATE;
              end else if (flg.bits_zero) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STS_NO_BITS;
              end else begin
                cmd.fcap_set = 1'b1;
              end
            end
          end
          PH_SKIP: begin
            cmd.proc = 1'b1;
            cmd.skip = 1'b1;
          end
          default: ;
        endcase
        fcap_fin = cmd.fcap_set || (flg.fcap_cur && !cmd.fmt_enter);
        if (cmd.proc && !cmd.emit && !cmd.div_start && last_byte) begin
          cmd.emit        = 1'b1;
          cmd.emit_fmt    = 1'b1;
          cmd.emit_status = (fcap_fin && flg.std_ok) ? STS_OK_STD : STS_OK_OTHER;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    if (state == PH_DIV) begin
      if (flg.div_last) state_next = PH_DONE;
    end else if (fire) begin
      if (first_byte) begin
        state_next = PH_HEAD;
        count_next = '0;
      end
      if (cmd.emit) begin
        state_next = PH_DONE;
      end else begin
        case (ph_eff)
          PH_HEAD: begin
            if (flg.pos_is11) begin
              state_next = PH_CHDR;
              count_next = '0;
            end
          end
          PH_CHDR: begin
            count_next = count_cur + 6'd1;
            if (cmd.fmt_enter) begin
              state_next = PH_FMT;
              count_next = '0;
            end else if (cmd.div_start) begin
              state_next = PH_DIV;
            end else if (cmd.skip_chunk) begin
              state_next = flg.size_zero ? PH_CHDR : PH_SKIP;
              count_next = '0;
            end
          end
          PH_FMT: begin
            count_next = count_cur + 6'd1;
            if (cmd.fmt_rest) begin
              state_next = flg.rest_zero ? PH_CHDR : PH_SKIP;
              count_next = '0;
            end
          end
          PH_SKIP: begin
            if (flg.skip_last) begin
              state_next = PH_CHDR;
              count_next = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

/* rtl/rwhp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_dp
// Parse registers, field capture, checks, frame divider and result register.
// ----------------------------------------------------------------------------
module rwhp_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [rwhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic [7:0]                     data_byte,
  input  rwhp_pkg::cmd_t                 cmd,
  output rwhp_pkg::flags_t               flg,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [3:0]                     status,
  output logic [13:0]                    bytes_per_channel,
  output logic [7:0]                     channels,
  output logic [15:0]                    sample_rate,
  output logic [31:0]                    data_offset,
  output logic [31:0]                    sample_count
);
  import rwhp_pkg::*;

  logic [31:0]        file_length;
  logic               custom_magic_enable;
  logic [31:0]        custom_magic;

  logic [LEN_W-1:0]   pos, pos_cur, pos_next;
  logic [31:0]        tag, tag_cur, tag_new, tag_next;
  logic [31:0]        field, field_cur, field_next;
  logic [LEN_W:0]     rem, rem_cur, rem_next, rest;
  logic [31:0]        clen, clen_cur, clen_next;
  logic [15:0]        fmtc, fmtc_cur, fmtc_next;
  logic [15:0]        chan, chan_cur, chan_next;
  logic [31:0]        rate, rate_cur, rate_next;
  logic [15:0]        bits, bits_cur, bits_next;
  logic [15:0]        extra, extra_cur, extra_next;
  logic               fcap, fcap_cur, fcap_next;
  logic [5:0]         consumed;

  logic [31:0]        offset, avail, dlen;
  logic [DIV_W-1:0]   prod;
  logic [31:0]        dquo, dquo_s;
  logic [DIV_W-1:0]   drem, drem_s, dvs;
  logic [DIV_W:0]     trial, diff;
  logic               ge;
  logic [DSTEP_W-1:0] dcnt;
  logic [31:0]        doff;
  logic [3:0]         dstat;

  assign pos_cur   = cmd.clear ? '0 : pos;
  assign tag_cur   = cmd.clear ? '0 : tag;
  assign field_cur = cmd.clear ? '0 : field;
  assign rem_cur   = cmd.clear ? '0 : rem;
  assign clen_cur  = cmd.clear ? '0 : clen;
  assign fmtc_cur  = cmd.clear ? '0 : fmtc;
  assign chan_cur  = cmd.clear ? '0 : chan;
  assign rate_cur  = cmd.clear ? '0 : rate;
  assign bits_cur  = cmd.clear ? '0 : bits;
  assign extra_cur = cmd.clear ? '0 : extra;
  assign fcap_cur  = cmd.clear ? 1'b0 : fcap;
  assign tag_new   = {data_byte, tag_cur[31:8]};

  always_comb begin
    field_next = field_cur;
    fmtc_next  = fmtc_cur;
    chan_next  = chan_cur;
    rate_next  = rate_cur;
    bits_next  = bits_cur;
    extra_next = extra_cur;
    if (cmd.chdr) begin
      case (cmd.k)
        6'd4:    field_next = {24'b0, data_byte};
        6'd5:    field_next[15:8] = data_byte;
        6'd6:    field_next[23:16] = data_byte;
        6'd7:    field_next[31:24] = data_byte;
        default: ;
      endcase
    end
    if (cmd.fmt_enter) extra_next = '0;
    if (cmd.fmt) begin
      case (cmd.k)
        6'd0:    fmtc_next = {8'b0, data_byte};
        6'd1:    fmtc_next[15:8] = data_byte;
        6'd2:    chan_next = {8'b0, data_byte};
        6'd3:    chan_next[15:8] = data_byte;
        6'd4:    rate_next = {24'b0, data_byte};
        6'd5:    rate_next[15:8] = data_byte;
        6'd6:    rate_next[23:16] = data_byte;
        6'd7:    rate_next[31:24] = data_byte;
        6'd14:   bits_next = {8'b0, data_byte};
        6'd15:   bits_next[15:8] = data_byte;
        6'd16:   extra_next = {8'b0, data_byte};
        6'd17:   extra_next[15:8] = data_byte;
        6'd24:   field_next = {24'b0, data_byte};
        6'd25:   fmtc_next = {data_byte, field_cur[7:0]};
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.k)
      6'd15:   consumed = 6'd16;
      6'd17:   consumed = 6'd18;
      default: consumed = 6'd40;
    endcase
  end

  assign rest = {1'b0, clen_cur} - {27'b0, consumed} + {32'b0, clen_cur[0]};

  always_comb begin
    flg           = '0;
    flg.len_small = file_length < MIN_FILE_LENGTH;
    flg.pos_is3   = pos_cur == 32'd3;
    flg.pos_is11  = pos_cur == 32'd11;
    flg.pos_lt3   = pos_cur < 32'd3;
    flg.magic_ok  = (tag_new == TAG_RIFF) ||
                    (custom_magic_enable && tag_new == custom_magic);
    flg.wave_ok   = tag_new == TAG_WAVE;
    flg.tag_fmt   = tag_cur == TAG_FMT;
    flg.tag_data  = tag_cur == TAG_DATA;
    flg.tag_print = printable(tag_cur);
    flg.size_lt16 = field_next < 32'd16;
    flg.size_zero = field_next == '0;
    flg.len_lt18  = clen_cur < 32'd18;
    flg.ext_ok    = (fmtc_next == FMT_EXTENSIBLE) && (extra_next >= 16'd22) &&
                    (clen_cur >= 32'd40);
    flg.fmt_bad   = fmtc_next != FMT_PCM;
    flg.chan_zero = chan_next[7:0] == 8'd0;
    flg.rate_bad  = (rate_next == '0) || (rate_next[31:16] != 16'd0);
    flg.bits_zero = bits_next == '0;
    flg.rest_zero = rest == '0;
    flg.fcap_cur  = fcap_cur;
    flg.std_ok    = (bits_next != '0) && (bits_next <= 16'd16) &&
                    (chan_next[7:0] == 8'd1 || chan_next[7:0] == 8'd2);
    flg.skip_last = rem_cur <= 33'd1;
    flg.div_last  = dcnt == '1;
    flg.out_busy  = out_valid && out_stall;
  end

  always_comb begin
    pos_next  = cmd.proc ? pos_cur + 32'd1 : pos_cur;
    tag_next  = (cmd.head || (cmd.chdr && cmd.k < 6'd4)) ? tag_new : tag_cur;
    clen_next = (cmd.chdr && cmd.k == 6'd7) ? field_next : clen_cur;
    rem_next  = rem_cur;
    if (cmd.skip_chunk) begin
      rem_next = {1'b0, field_next} + {32'b0, field_next[0]};
    end else if (cmd.fmt_rest) begin
      rem_next = rest;
    end else if (cmd.skip && rem_cur != '0) begin
      rem_next = rem_cur - 33'd1;
    end
    fcap_next = fcap_cur;
    if (cmd.fmt_enter) fcap_next = 1'b0;
    if (cmd.fcap_set) fcap_next = 1'b1;
  end

  assign offset = pos_cur + 32'd1;
  assign avail  = (file_length >= offset) ? file_length - offset : '0;
  assign dlen   = (field_next < avail) ? field_next : avail;
  assign prod   = {8'b0, bpc_of(bits_cur)} * {14'b0, chan_cur[7:0]};

  assign trial  = {drem, dquo[31]};
  assign diff   = trial - {1'b0, dvs};
  assign ge     = trial >= {1'b0, dvs};
  assign drem_s = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  assign dquo_s = {dquo[30:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length         <= '0;
      custom_magic_enable <= 1'b0;
      custom_magic        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FILE_LENGTH:  file_length <= cfg_data;
        CFG_MAGIC_ENABLE: custom_magic_enable <= cfg_data[0];
        CFG_CUSTOM_MAGIC: custom_magic <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    tag   <= tag_next;
    field <= field_next;
    rem   <= rem_next;
    clen  <= clen_next;
    fmtc  <= fmtc_next;
    chan  <= chan_next;
    rate  <= rate_next;
    bits  <= bits_next;
    extra <= extra_next;
    fcap  <= fcap_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dquo  <= dlen;
      drem  <= '0;
      dvs   <= (prod == '0) ? {{(DIV_W-1){1'b0}}, 1'b1} : prod;
      dcnt  <= '0;
      doff  <= offset;
      dstat <= cmd.emit_status;
    end else if (cmd.div_step) begin
      dquo <= dquo_s;
      drem <= drem_s;
      dcnt <= dcnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_div) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_div) begin
      status            <= dstat;
      bytes_per_channel <= bpc_of(bits);
      channels          <= chan[7:0];
      sample_rate       <= rate[15:0];
      data_offset       <= doff;
      sample_count      <= dquo_s;
    end else if (cmd.emit) begin
      status            <= cmd.emit_status;
      bytes_per_channel <= (cmd.emit_fmt && fcap_next) ? bpc_of(bits_next) : '0;
      channels          <= (cmd.emit_fmt && fcap_next) ? chan_next[7:0] : '0;
      sample_rate       <= (cmd.emit_fmt && fcap_next) ? rate_next[15:0] : '0;
      data_offset       <= '0;
      sample_count      <= '0;
    end
  end

endmodule

/* rtl/rwhp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_checker
// Port-level checks of the header parser, bound to the top level.
// ----------------------------------------------------------------------------
module rwhp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [7:0]                     data_byte,
  input logic                           first_byte,
  input logic                           last_byte,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [3:0]                     status,
  input logic [13:0]                    bytes_per_channel,
  input logic [7:0]                     channels,
  input logic [15:0]                    sample_rate,
  input logic [31:0]                    data_offset,
  input logic [31:0]                    sample_count,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [rwhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                    cfg_data
);
  import rwhp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(sample_count))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= STS_BAD_TAG)
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status >= STS_TOO_SMALL |->
      bytes_per_channel == '0 && channels == '0 && sample_rate == '0 &&
      data_offset == '0 && sample_count == '0)
    else $error("error result carries nonzero fields");

  a_std_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STS_OK_STD |->
      (bytes_per_channel == 14'd1 || bytes_per_channel == 14'd2) &&
      (channels == 8'd1 || channels == 8'd2))
    else $error("standard status with nonstandard shape");

endmodule

bind riff_wave_header_parser rwhp_checker u_rwhp_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the RIFF/WAVE header parser. Whole files are built in memory
// (good headers, broken magic and tags, every fmt fault, extensible fmt and
// truncated data chunks) and streamed a byte at a time with random gaps,
// while the result side stalls on its own pattern. A byte-level model of the
// parser predicts the one result, if any, of each file, and every result
// transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import rwhp_pkg::*;

  typedef struct {
    logic [3:0]  status;
    logic [13:0] bpc;
    logic [7:0]  chans;
    logic [15:0] rate;
    logic [31:0] offset;
    logic [31:0] count;
  } wav_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  status;
  logic [13:0] bytes_per_channel;
  logic [7:0]  channels;
  logic [15:0] sample_rate;
  logic [31:0] data_offset;
  logic [31:0] sample_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  riff_wave_header_parser u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .first_byte(first_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .bytes_per_channel(bytes_per_channel), .channels(channels),
    .sample_rate(sample_rate), .data_offset(data_offset), .sample_count(sample_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // parser model state
  logic [31:0] file_len;
  logic        magic_en;
  logic [31:0] magic_w;
  phase_t      parse_ph;
  logic [31:0] byte_pos;
  logic [31:0] tag_sh;
  logic [31:0] field_sh;
  logic [32:0] skip_left;
  logic [31:0] chunk_len;
  logic [15:0] fmt_code;
  logic [15:0] chan_w;
  logic [31:0] rate_w;
  logic [15:0] bits_w;
  logic [15:0] ext_w;
  logic        fmt_ok;
  int unsigned step_k;
  bit          emitted;

  wav_result_t pending_results[$];
  logic [7:0]  wav_bytes[$];
  int          errors;
  int          n_bytes;
  int          n_results;
  int          burst_left;
  int          stall_left;
  int          stall_mode;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- prediction ----------------
  function automatic void clear_parse();
    parse_ph = PH_IDLE;
    byte_pos = '0;
    tag_sh = '0;
    field_sh = '0;
    skip_left = '0;
    chunk_len = '0;
    fmt_code = '0;
    chan_w = '0;
    rate_w = '0;
    bits_w = '0;
    ext_w = '0;
    fmt_ok = 1'b0;
    step_k = 0;
  endfunction

  function automatic logic [13:0] frame_bytes();
    logic [16:0] s;
    s = {1'b0, bits_w} + 17'd7;
    return fmt_ok ? s[16:3] : 14'd0;
  endfunction

  function automatic logic [7:0] chan_low();
    return fmt_ok ? chan_w[7:0] : 8'd0;
  endfunction

  function automatic logic [3:0] end_status();
    if (fmt_ok && (frame_bytes() == 1 || frame_bytes() == 2) &&
        (chan_low() == 1 || chan_low() == 2)) return STS_OK_STD;
    return STS_OK_OTHER;
  endfunction

  function automatic bit tag_is_text(input logic [31:0] t);
    for (int i = 0; i < 4; i++) begin
      if (t[8*i +: 8] < 8'd32 || t[8*i +: 8] > 8'd126) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void emit_result(input logic [3:0] st, input bit with_fmt,
                                      input logic [31:0] off, input logic [31:0] cnt);
    wav_result_t r;
    r.status = st;
    r.bpc = with_fmt ? frame_bytes() : 14'd0;
    r.chans = with_fmt ? chan_low() : 8'd0;
    r.rate = (with_fmt && fmt_ok) ? rate_w[15:0] : 16'd0;
    r.offset = off;
    r.count = cnt;
    pending_results.push_back(r);
    n_results++;
    parse_ph = PH_DONE;
    emitted = 1'b1;
  endfunction

  function automatic void start_skip(input logic [32:0] n);
    skip_left = n;
    step_k = 0;
    parse_ph = (n == 0) ? PH_CHDR : PH_SKIP;
  endfunction

  function automatic void close_fmt(input int unsigned consumed);
    start_skip({1'b0, chunk_len} - consumed + chunk_len[0]);
    if (fmt_code != FMT_PCM) emit_result(STS_NOT_PCM, 0, 0, 0);
    else if (chan_w[7:0] == 0) emit_result(STS_NO_CHANNELS, 0, 0, 0);
    else if (rate_w == 0 || rate_w > 32'hFFFF) emit_result(STS_BAD_RATE, 0, 0, 0);
    else if (bits_w == 0) emit_result(STS_NO_BITS, 0, 0, 0);
    else fmt_ok = 1'b1;
  endfunction

  function automatic void close_header(input logic [31:0] pos);
    logic [31:0] off;
    logic [31:0] avail;
    logic [31:0] len;
    int unsigned dv;
    chunk_len = field_sh;
    step_k = 0;
    if (tag_sh == TAG_FMT) begin
      if (field_sh < 16) begin
        emit_result(STS_FMT_SMALL, 0, 0, 0);
      end else begin
        fmt_ok = 1'b0;
        ext_w = '0;
        parse_ph = PH_FMT;
      end
    end else if (tag_sh == TAG_DATA) begin
      if (!fmt_ok) begin
        emit_result(STS_DATA_EARLY, 0, 0, 0);
      end else begin
        off = pos + 32'd1;
        avail = (file_len >= off) ? file_len - off : 32'd0;
        len = (field_sh > avail) ? avail : field_sh;
        dv = frame_bytes() * chan_low();
        if (dv == 0) dv = 1;
        emit_result(end_status(), 1, off, len / dv);
      end
    end else if (!tag_is_text(tag_sh)) begin
      emit_result(STS_BAD_TAG, 0, 0, 0);
    end else begin
      start_skip({1'b0, field_sh} + field_sh[0]);
    end
  endfunction

  function automatic void take_fmt_byte(input logic [7:0] b);
    int unsigned k;
    k = step_k;
    step_k++;
    if (k < 2) fmt_code[8*k +: 8] = b;
    else if (k < 4) chan_w[8*(k-2) +: 8] = b;
    else if (k < 8) begin
      if (k == 4) rate_w = {24'd0, b};
      else rate_w[8*(k-4) +: 8] = b;
    end else if (k == 14) bits_w = {8'd0, b};
    else if (k == 15) bits_w[15:8] = b;
    else if (k == 16) ext_w = {8'd0, b};
    else if (k == 17) ext_w[15:8] = b;
    else if (k == 24) field_sh = {24'd0, b};
    else if (k == 25) fmt_code = {b, field_sh[7:0]};
    if (k == 15 && chunk_len < 18) close_fmt(16);
    else if (k == 17 && !(fmt_code == FMT_EXTENSIBLE && ext_w >= 22 && chunk_len >= 40))
      close_fmt(18);
    else if (k == 39) close_fmt(40);
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic f, input logic l);
    logic [31:0] pos;
    int unsigned k;
    emitted = 1'b0;
    if (f) begin
      clear_parse();
      parse_ph = PH_HEAD;
      if (file_len < MIN_FILE_LENGTH) begin
        emit_result(STS_TOO_SMALL, 0, 0, 0);
        return;
      end
    end
    if (parse_ph == PH_IDLE || parse_ph == PH_DONE) return;
    pos = byte_pos;
    byte_pos = byte_pos + 32'd1;
    case (parse_ph)
      PH_HEAD: begin
        tag_sh = {b, tag_sh[31:8]};
        if (pos == 3) begin
          if (!(tag_sh == TAG_RIFF || (magic_en && tag_sh == magic_w)))
            emit_result(STS_NOT_RIFF, 0, 0, 0);
        end else if (pos == 11) begin
          if (tag_sh != TAG_WAVE) emit_result(STS_NOT_WAVE, 0, 0, 0);
          else begin
            parse_ph = PH_CHDR;
            step_k = 0;
          end
        end
        if (!emitted && parse_ph == PH_HEAD && l)
          emit_result((pos < 3) ? STS_NOT_RIFF : STS_NOT_WAVE, 0, 0, 0);
      end
      PH_CHDR: begin
        k = step_k;
        step_k++;
        if (k < 4) tag_sh = {b, tag_sh[31:8]};
        else if (k == 4) field_sh = {24'd0, b};
        else field_sh[8*(k-4) +: 8] = b;
        if (k >= 7) close_header(pos);
      end
      PH_FMT: take_fmt_byte(b);
      default: begin
        if (skip_left > 0) skip_left = skip_left - 33'd1;
        if (skip_left == 0) begin
          parse_ph = PH_CHDR;
          step_k = 0;
        end
      end
    endcase
    if (!emitted && l && parse_ph != PH_DONE) emit_result(end_status(), 1, 0, 0);
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    wav_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status), 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (status !== w.status)
          report_mismatch("status", 32'(status), 32'(w.status));
        if (bytes_per_channel !== w.bpc)
          report_mismatch("bytes_per_channel", 32'(bytes_per_channel), 32'(w.bpc));
        if (channels !== w.chans)
          report_mismatch("channels", 32'(channels), 32'(w.chans));
        if (sample_rate !== w.rate)
          report_mismatch("sample_rate", 32'(sample_rate), 32'(w.rate));
        if (data_offset !== w.offset)
          report_mismatch("data_offset", data_offset, w.offset);
        if (sample_count !== w.count)
          report_mismatch("sample_count", sample_count, w.count);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 120);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ((stall_left % 6) < 2);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("riff_wave_header_parser verification failed");
      $finish;
    end
  end

  // ---------------- driving ----------------
  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    data_byte <= b;
    first_byte <= f;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_byte(b, f, l);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic send_file(input bit with_last);
    for (int i = 0; i < wav_bytes.size(); i++)
      send_byte(wav_bytes[i], i == 0, with_last && i == wav_bytes.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    case (idx)
      CFG_FILE_LENGTH:  file_len = val;
      CFG_MAGIC_ENABLE: magic_en = val[0];
      default:          magic_w = val;
    endcase
  endtask

  task automatic set_config(input logic [31:0] len, input logic en, input logic [31:0] mg);
    settle();
    cfg_write(CFG_FILE_LENGTH, len);
    cfg_write(CFG_MAGIC_ENABLE, {31'd0, en});
    cfg_write(CFG_CUSTOM_MAGIC, mg);
    cfg_valid <= 1'b0;
  endtask

  // ---------------- file building ----------------
  function automatic void put32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) wav_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_head(input logic [31:0] magic, input logic [31:0] wave);
    wav_bytes.delete();
    put32(magic);
    put32($urandom);
    put32(wave);
  endfunction

  function automatic void put_fmt(input int size, input logic [15:0] code,
                                  input logic [15:0] ch, input logic [31:0] rate,
                                  input logic [15:0] bits, input logic [15:0] ext,
                                  input logic [15:0] sub);
    logic [7:0] body[40];
    put32(TAG_FMT);
    put32(size);
    for (int i = 0; i < 40; i++) body[i] = 8'($urandom);
    {body[1], body[0]} = code;
    {body[3], body[2]} = ch;
    {body[7], body[6], body[5], body[4]} = rate;
    {body[15], body[14]} = bits;
    {body[17], body[16]} = ext;
    {body[25], body[24]} = sub;
    for (int i = 0; i < size + size % 2; i++)
      wav_bytes.push_back((i < 40) ? body[i] : 8'($urandom));
  endfunction

  function automatic void put_chunk(input logic [31:0] tag, input int size);
    put32(tag);
    put32(size);
    for (int i = 0; i < size + size % 2; i++) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_data(input logic [31:0] size, input int nbytes);
    put32(TAG_DATA);
    put32(size);
    for (int i = 0; i < nbytes; i++) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] text_tag();
    logic [31:0] t;
    for (int i = 0; i < 4; i++) t[8*i +: 8] = 8'($urandom_range(32, 126));
    return t;
  endfunction

  function automatic void put_pcm(input logic [15:0] ch, input logic [15:0] bits);
    put_fmt(16, FMT_PCM, ch, 44100, bits, 0, 0);
  endfunction

  // ---------------- tests ----------------
  task automatic test_file_size();
    set_config(32'd0, 1'b0, 32'd0);
    put_head(TAG_RIFF, TAG_WAVE);
    send_file(1);
    set_config(32'd27, 1'b0, 32'd0);
    send_file(0);
  endtask

  task automatic test_magic();
    logic [31:0] mg;
    mg = $urandom;
    set_config(32'hFFFF_FFFF, 1'b1, mg);
    put_head(mg, TAG_WAVE);
    put_pcm(1, 8);
    put_data(100, 2);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_pcm(2, 16);
    send_file(1);
    put_head(mg ^ 32'h0100_0000, TAG_WAVE);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE ^ 32'h0000_0020);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    wav_bytes = wav_bytes[0:2];
    send_file(1);
    wav_bytes = wav_bytes[0:1];
    wav_bytes.push_back(8'h46);
    wav_bytes.push_back(8'h46);
    wav_bytes.push_back(8'h00);
    wav_bytes.push_back(8'hFF);
    send_file(1);
    set_config(32'd28, 1'b0, 32'hFFFF_FFFF);
    put_head(mg, TAG_WAVE);
    send_file(1);
  endtask

  task automatic test_fmt_checks();
    set_config(32'd5000, 1'b0, 32'd0);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(15, FMT_PCM, 1, 8000, 8, 0, 0);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(16, 16'h0003, 1, 8000, 8, 0, 0);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(16, FMT_PCM, 16'h0100, 8000, 8, 0, 0);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(16, FMT_PCM, 2, 0, 8, 0, 0);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(16, FMT_PCM, 2, 32'h0001_0000, 8, 0, 0);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(16, FMT_PCM, 2, 65535, 0, 0, 0);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_data(10, 3);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_chunk(text_tag(), 3);
    put_chunk(32'h1F41_4141, 2);
    send_file(1);
  endtask

  task automatic test_extensible();
    set_config(32'd200, 1'b0, 32'd0);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(40, FMT_EXTENSIBLE, 2, 48000, 24, 22, FMT_PCM);
    put_data(32'hFFFF_FFFF, 1);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(40, FMT_EXTENSIBLE, 2, 48000, 16, 22, 16'h0003);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(40, FMT_EXTENSIBLE, 2, 48000, 16, 21, FMT_PCM);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_fmt(17, FMT_PCM, 1, 22050, 16'hFFFF, 0, 0);
    put_chunk(text_tag(), 0);
    put_data(40, 0);
    send_file(1);
  endtask

  task automatic test_data_size();
    set_config(32'd40, 1'b0, 32'd0);
    put_head(TAG_RIFF, TAG_WAVE);
    put_pcm(2, 16);
    put_chunk(text_tag(), 30);
    put_data(1000, 4);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_pcm(2, 16);
    put_data(1000, 4);
    send_file(1);
    put_head(TAG_RIFF, TAG_WAVE);
    put_pcm(2, 16);
    put_chunk(text_tag(), 5);
    send_file(1);
  endtask

  task automatic build_random_file();
    int r;
    int fsz;
    logic [15:0] code;
    logic [15:0] ch;
    logic [31:0] rate;
    logic [15:0] bits;
    r = $urandom_range(0, 99);
    put_head((r < 6) ? 32'($urandom) : (magic_en && r < 40) ? magic_w : TAG_RIFF,
             ($urandom_range(0, 19) == 0) ? 32'($urandom) : TAG_WAVE);
    if ($urandom_range(0, 9) == 0) put_data($urandom_range(0, 9), 0);
    if ($urandom_range(0, 3) == 0) put_chunk(text_tag(), $urandom_range(0, 9));
    if ($urandom_range(0, 14) != 0) begin
      case ($urandom_range(0, 6))
        0, 1: fsz = 16;
        2: fsz = 17;
        3: fsz = 18;
        4, 5: fsz = 40;
        default: fsz = $urandom_range(12, 48);
      endcase
      r = $urandom_range(0, 9);
      code = (r < 7) ? FMT_PCM : (r < 9) ? FMT_EXTENSIBLE : 16'($urandom);
      r = $urandom_range(0, 9);
      ch = (r < 7) ? 16'($urandom_range(1, 2)) : (r < 8) ? 16'd0 : 16'($urandom);
      r = $urandom_range(0, 9);
      rate = (r < 8) ? $urandom_range(1, 65535) : (r < 9) ? 32'd0 : 32'($urandom);
      case ($urandom_range(0, 5))
        0: bits = 8;
        1: bits = 16;
        2: bits = 24;
        3: bits = 32;
        4: bits = 16'($urandom_range(0, 64));
        default: bits = 16'($urandom);
      endcase
      put_fmt(fsz, code, ch, rate, bits,
              ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd22,
              ($urandom_range(0, 4) == 0) ? 16'($urandom) : FMT_PCM);
    end
    if ($urandom_range(0, 5) == 0) put_chunk(text_tag(), $urandom_range(0, 12));
    if ($urandom_range(0, 24) == 0) put_chunk($urandom, $urandom_range(0, 4));
    if ($urandom_range(0, 9) != 0)
      put_data(($urandom_range(0, 2) == 0) ? 32'($urandom) : $urandom_range(0, 300),
               $urandom_range(0, 6));
    else
      put_chunk(text_tag(), $urandom_range(0, 6));
  endtask

  task automatic test_random();
    int stop_bytes;
    int cut;
    stop_bytes = 1550;
    while (n_bytes < stop_bytes) begin
      if (n_bytes % 400 < 60 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: set_config(32'hFFFF_FFFF, 1'b1, $urandom);
          1: set_config(32'd28, 1'b1, 32'hFFFF_FFFF);
          2: set_config($urandom_range(28, 400), 1'b0, 32'd0);
          default: set_config($urandom, 1'($urandom_range(0, 1)), TAG_WAVE);
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
      end
      build_random_file();
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, wav_bytes.size());
        wav_bytes = wav_bytes[0:cut-1];
      end
      send_file($urandom_range(0, 6) != 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    first_byte = 1'b0;
    last_byte = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FILE_LENGTH;
    cfg_data = '0;
    errors = 0;
    n_bytes = 0;
    n_results = 0;
    burst_left = 0;
    stall_left = 0;
    idle_cycles = 0;
    file_len = '0;
    magic_en = 1'b0;
    magic_w = '0;
    clear_parse();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_file_size();
    test_magic();
    test_fmt_checks();
    test_extensible();
    test_data_size();
    test_random();
    settle();
    if (errors == 0) begin
      $display("riff_wave_header_parser verification clean");
    end else begin
      $display("riff_wave_header_parser verification failed");
    end
    $finish;
  end

endmodule
